### rtl/nlsc_pkg.sv
package nlsc_pkg;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LOW_E = 8'h65;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    localparam logic [1:0] DOT_MAX = 2'd2;

    typedef struct packed {
        logic       string_start;
        logic       mant_nonempty;
        logic [1:0] mant_dots;
        logic       mant_bad;
        logic       exp_seen;
        logic       exp_start;
        logic       exp_nonempty;
        logic       exp_bad;
    } scan_state_t;

    typedef struct packed {
        logic int_ok;
        logic decimal_ok;
        logic scientific_ok;
    } verdict_t;

    localparam scan_state_t SCAN_RESET = '{
        string_start:  1'b1,
        mant_nonempty: 1'b0,
        mant_dots:     2'd0,
        mant_bad:      1'b0,
        exp_seen:      1'b0,
        exp_start:     1'b0,
        exp_nonempty:  1'b0,
        exp_bad:       1'b0
    };

    function automatic scan_state_t scan_step(scan_state_t s, logic [7:0] ch);
        scan_state_t n;
        logic        is_digit;
        logic        is_sign;
        logic        is_e;
        n        = s;
        is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        is_sign  = (ch == CH_MINUS) || (ch == CH_PLUS);
        is_e     = (ch == CH_LOW_E) || (ch == CH_UP_E);
        n.string_start = 1'b0;
        if (!s.exp_seen)
        begin
            if (is_e)
            begin
                n.exp_seen  = 1'b1;
                n.exp_start = 1'b1;
            end
            else if (!(s.string_start && is_sign))
            begin
                n.mant_nonempty = 1'b1;
                if (ch == CH_DOT)
                begin
                    if (s.mant_dots != DOT_MAX)
                    begin
                        n.mant_dots = s.mant_dots + 2'd1;
                    end
                end
                else if (!is_digit)
                begin
                    n.mant_bad = 1'b1;
                end
            end
        end
        else
        begin
            n.exp_start = 1'b0;
            if (is_e)
            begin
                n.exp_bad      = 1'b1;
                n.exp_nonempty = 1'b1;
            end
            else if (!(s.exp_start && is_sign))
            begin
                n.exp_nonempty = 1'b1;
                if (!is_digit)
                begin
                    n.exp_bad = 1'b1;
                end
            end
        end
        return n;
    endfunction

    function automatic verdict_t scan_verdict(scan_state_t s);
        verdict_t v;
        logic     mant_ok;
        mant_ok      = s.mant_nonempty && !s.mant_bad && (s.mant_dots != DOT_MAX);
        v.decimal_ok = mant_ok && !s.exp_seen;
        v.int_ok     = v.decimal_ok && (s.mant_dots == 2'd0);
        v.scientific_ok = s.exp_seen ? (mant_ok && s.exp_nonempty && !s.exp_bad)
                                     : mant_ok;
        return v;
    endfunction

endpackage

### rtl/numeric_literal_syntax_checker.sv
// Channel | Handshake          | Payload
// --------+--------------------+---------------------------------------
// in      | in_valid/in_ready  | character[7:0], final_char
// out     | out_valid/out_ready| int_ok, decimal_ok, scientific_ok
//
// One character per cycle sustained. The result register and out_valid load
// together as the final character leaves the input register.
// The scan state updates as a character leaves the input register.
// Reset empties both registers and returns the scan state to string start.
// A stalled result blocks only a final character; others keep flowing.
module numeric_literal_syntax_checker
    import nlsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] character,
    input  logic       final_char,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       int_ok,
    output logic       decimal_ok,
    output logic       scientific_ok
);

    logic        s1_valid_reg;
    logic [7:0]  s1_char_reg;
    logic        s1_final_reg;
    scan_state_t state_reg;
    scan_state_t state_next;
    scan_state_t stepped;
    verdict_t    verdict_next;
    verdict_t    verdict_reg;
    logic        out_valid_reg;
    logic        s1_adv;
    logic        result_load;

    assign stepped      = scan_step(state_reg, s1_char_reg);
    assign verdict_next = scan_verdict(stepped);

    // a final character needs a free result slot to leave stage one
    assign s1_adv      = s1_valid_reg && (!s1_final_reg || !out_valid_reg || out_ready);
    assign result_load = s1_adv && s1_final_reg;
    assign in_ready    = !s1_valid_reg || s1_adv;
    assign state_next  = s1_final_reg ? SCAN_RESET : stepped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= SCAN_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_adv)
            begin
                state_reg <= state_next;
            end
            if (result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_char_reg  <= character;
            s1_final_reg <= final_char;
        end
        if (result_load)
        begin
            verdict_reg <= verdict_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign int_ok        = verdict_reg.int_ok;
    assign decimal_ok    = verdict_reg.decimal_ok;
    assign scientific_ok = verdict_reg.scientific_ok;

    a_int_implies_dec: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!int_ok || decimal_ok))
        else $error("integer verdict without decimal verdict");

    a_dec_implies_sci: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!decimal_ok || scientific_ok))
        else $error("decimal verdict without scientific verdict");

    a_restart_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        result_load |=> (state_reg == SCAN_RESET))
        else $error("scan state not cleared after final character");

    a_result_follows_final: assert property (@(posedge clk) disable iff (!rst_n)
        result_load |=> out_valid)
        else $error("final character produced no result");

    a_dots_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.mant_dots != 2'd3)
        else $error("dot count out of range");

endmodule

### tb/sv/tb_numeric_literal_syntax_checker.sv
`timescale 1ns / 1ps

module tb_numeric_literal_syntax_checker;
    import nlsc_pkg::*;

    localparam int CHAR_TARGET = 1350;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 10;

    class verdict_board;
        logic       at_start;
        logic       body_seen;
        logic [1:0] dots;
        logic       body_junk;
        logic       in_exp;
        logic       exp_first;
        logic       exp_body;
        logic       exp_junk;
        verdict_t   pending[$];
        int         failures;

        function new();
            failures = 0;
            restart();
        endfunction

        function void restart();
            at_start  = 1'b1;
            body_seen = 1'b0;
            dots      = 2'd0;
            body_junk = 1'b0;
            in_exp    = 1'b0;
            exp_first = 1'b0;
            exp_body  = 1'b0;
            exp_junk  = 1'b0;
        endfunction

        // Advance the scan by one accepted character; queue a verdict on the last one.
        function void take_char(logic [7:0] ch, logic last);
            logic     first;
            logic     efirst;
            logic     e_mark;
            logic     sign;
            logic     digit;
            logic     mant_good;
            verdict_t v;
            first  = at_start;
            e_mark = (ch == CH_LOW_E) || (ch == CH_UP_E);
            sign   = (ch == CH_PLUS) || (ch == CH_MINUS);
            digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
            at_start = 1'b0;
            if (!in_exp)
            begin
                if (e_mark)
                begin
                    in_exp    = 1'b1;
                    exp_first = 1'b1;
                end
                else if (!(first && sign))
                begin
                    body_seen = 1'b1;
                    if (ch == CH_DOT)
                    begin
                        if (dots != DOT_MAX)
                            dots = dots + 2'd1;
                    end
                    else if (!digit)
                    begin
                        body_junk = 1'b1;
                    end
                end
            end
            else
            begin
                efirst    = exp_first;
                exp_first = 1'b0;
                if (e_mark)
                begin
                    exp_junk = 1'b1;
                    exp_body = 1'b1;
                end
                else if (!(efirst && sign))
                begin
                    exp_body = 1'b1;
                    if (!digit)
                        exp_junk = 1'b1;
                end
            end
            if (last)
            begin
                mant_good    = body_seen && !body_junk && (dots != DOT_MAX);
                v.decimal_ok = mant_good && !in_exp;
                v.int_ok     = v.decimal_ok && (dots == 2'd0);
                v.scientific_ok = in_exp ? (mant_good && exp_body && !exp_junk) : mant_good;
                pending.push_back(v);
                restart();
            end
        endfunction

        function void check_verdict(logic i_ok, logic d_ok, logic s_ok);
            verdict_t want;
            if (pending.size() == 0)
            begin
                $error("verdict transfer with nothing expected");
                failures++;
                return;
            end
            want = pending.pop_front();
            if (i_ok !== want.int_ok)
            begin
                $error("int_ok: expected %0b, actual %0b", want.int_ok, i_ok);
                failures++;
            end
            if (d_ok !== want.decimal_ok)
            begin
                $error("decimal_ok: expected %0b, actual %0b", want.decimal_ok, d_ok);
                failures++;
            end
            if (s_ok !== want.scientific_ok)
            begin
                $error("scientific_ok: expected %0b, actual %0b", want.scientific_ok, s_ok);
                failures++;
            end
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] character;
    logic       final_char;
    logic       out_valid;
    logic       out_ready;
    logic       int_ok;
    logic       decimal_ok;
    logic       scientific_ok;

    verdict_board board;
    int           chars_sent;
    int           cycles;
    logic         calm;

    numeric_literal_syntax_checker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .character     (character),
        .final_char    (final_char),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .int_ok        (int_ok),
        .decimal_ok    (decimal_ok),
        .scientific_ok (scientific_ok)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    task automatic send_char(logic [7:0] ch, logic last);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   = 1'b1;
        character  = ch;
        final_char = last;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        board.take_char(ch, last);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_literal(ref logic [7:0] text[$]);
        foreach (text[i])
            send_char(text[i], i == text.size() - 1);
    endtask

    task automatic add_digits(ref logic [7:0] text[$], input int n);
        repeat (n) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // Mostly well-formed literals with random content; some broken, some noise.
    task automatic make_literal(ref logic [7:0] text[$]);
        int kind;
        int pos;
        logic [7:0] junk;
        text.delete();
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            if ($urandom_range(0, 2) == 0)
                text.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            add_digits(text, $urandom_range(0, 4));
            if ($urandom_range(0, 1))
                text.push_back(CH_DOT);
            add_digits(text, $urandom_range(0, 3));
            if ($urandom_range(0, 1))
            begin
                text.push_back($urandom_range(0, 1) ? CH_LOW_E : CH_UP_E);
                if ($urandom_range(0, 1))
                    text.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                add_digits(text, $urandom_range(0, 3));
            end
            if (kind < 35)
            begin
                case ($urandom_range(0, 5))
                    0: junk = CH_DOT;
                    1: junk = CH_PLUS;
                    2: junk = CH_MINUS;
                    3: junk = CH_LOW_E;
                    4: junk = CH_UP_E;
                    default: junk = 8'($urandom_range(0, 255));
                endcase
                pos = $urandom_range(0, text.size());
                text.insert(pos, junk);
            end
        end
        if (text.size() == 0)
            add_digits(text, 1);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready === 1'b1)
            board.check_verdict(int_ok, decimal_ok, scientific_ok);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        @(negedge clk);
        forever
        begin
            int stall;
            stall = gap_len();
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    end

    initial
    begin
        logic [7:0] text[$];
        string      cases[$];
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        character  = 8'd0;
        final_char = 1'b0;
        out_ready  = 1'b0;
        cycles     = 0;
        chars_sent = 0;
        calm       = 1'b0;
        board      = new();
        cases = '{"+", "-9", ".", "..", "1+2", "2E-7", "+e1", "a", "1e5e"};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // byte extremes first, then the named corner strings
        text = '{8'h00};
        send_literal(text);
        text = '{8'hFF};
        send_literal(text);
        foreach (cases[k])
        begin
            text.delete();
            for (int j = 0; j < cases[k].len(); j++)
                text.push_back(cases[k][j]);
            send_literal(text);
        end

        while (chars_sent < CHAR_TARGET)
        begin
            if ($urandom_range(0, 15) == 0)
                calm = !calm;
            make_literal(text);
            send_literal(text);
        end
        in_valid   = 1'b0;
        final_char = 1'b0;

        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
